[rtl/mhtq_pkg.sv]
`default_nettype none
package mhtq_pkg;

    // input commands (s_tuser)
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // result status codes (m_tuser)
    localparam logic [2:0] ST_NONE   = 3'd0;
    localparam logic [2:0] ST_FIRED  = 3'd1;
    localparam logic [2:0] ST_CANCEL = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_OK     = 3'd4;

    localparam int ID_BITS   = 10;
    localparam int LVL_BITS  = 3;   // heap levels 0..6 at most
    localparam int PAIR_BITS = 5;   // sibling pairs per level, 32 at most

    // write command broadcast along the row of level cells
    typedef struct packed {
        logic                 en;
        logic [LVL_BITS-1:0]  lvl;
        logic [PAIR_BITS-1:0] pair;
        logic                 side;
    } cell_wr_t;

endpackage
`default_nettype wire

[rtl/min_heap_timer_queue.sv]
`default_nettype none
// Binary min-heap timer queue. Commands arrive on the s_ stream (s_tuser: 0 add, 1 cancel,
// 2 tick, 3 other); results leave on the m_ stream, one per add, cancel or other command,
// one per popped timer on a tick (or a single "nothing expired"), with m_tlast on the
// final result of each command. The heap lives in a row of level cells, one per heap
// level, each holding its level's entries as sibling pairs; sift-up and sift-down move one
// level per cycle between neighbouring cells. A tick handles each popped timer as pop,
// mark read, at most levels-1 sift-down steps, then check; each sift step is one cell read
// and one cell write. Cancel marks sit in a RAM cleared by a pass over all NUM_IDS entries
// after reset, during which s_tready stays low. One command is worked on at a time; the
// output register lets the next command in while a result still waits for m_tready.
module min_heap_timer_queue #(
    parameter int CAPACITY  = 64,
    parameter int NUM_IDS   = 1024,
    parameter int TIME_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // timer_id[9:0], time_value[41:10], zero pad
    input  wire logic [1:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // expired_id[9:0], expired_time[41:10],
                                        // entries_left[48:42], zero pad
    output logic      [2:0]  m_tuser,   // status
    output logic             m_tlast
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NW   = CW + 1;
    localparam int NLVL = CW;
    localparam int EW   = mhtq_pkg::ID_BITS + TIME_BITS;
    localparam int IDW  = $clog2(NUM_IDS);
    localparam int LW   = mhtq_pkg::LVL_BITS;
    localparam int PB   = mhtq_pkg::PAIR_BITS;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_UP   = 4'd2;
    localparam logic [3:0] S_RESP = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_POPA = 4'd5;
    localparam logic [3:0] S_POPB = 4'd6;
    localparam logic [3:0] S_DOWN = 4'd7;

    // position of the top set bit: heap level of a 1-based index
    function automatic logic [LW-1:0] lvl_of(input logic [NW-1:0] n);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (n[i])
                r = LW'(i);
        end
        return r;
    endfunction

    // offset of a 1-based index within its level
    function automatic logic [NW-1:0] off_of(input logic [NW-1:0] n, input logic [LW-1:0] l);
        return n & ~(NW'(1) << l);
    endfunction

    // control and payload registers
    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [EW-1:0]        item_reg, item_next;
    logic [EW-1:0]        top_reg, top_next;
    logic [TIME_BITS-1:0] tv_reg, tv_next;
    logic                 dead_reg, dead_next;
    logic                 idok_reg, idok_next;
    logic                 pend_reg, pend_next;
    logic [2:0]           res_reg, res_next;
    logic [IDW-1:0]       clr_reg, clr_next;

    logic                 oval_reg, oval_next;
    logic [2:0]           ost_reg, ost_next;
    logic [9:0]           oid_reg, oid_next;
    logic [31:0]          otime_reg, otime_next;
    logic [6:0]           oleft_reg, oleft_next;
    logic                 olast_reg, olast_next;

    // cell row
    mhtq_pkg::cell_wr_t   cwr;
    logic [EW-1:0]        cwr_data;
    logic [PB-1:0]        rd_pair;
    logic [LW-1:0]        rd_lvl;
    logic [2*EW-1:0]      cell_rd [NLVL];
    logic [2*EW-1:0]      rd_word;

    // cancel marks
    logic                 ram_we;
    logic [IDW-1:0]       ram_waddr;
    logic                 ram_wdata;
    logic [IDW-1:0]       ram_raddr;
    logic                 ram_rdata;

    logic                 accept;
    logic                 out_free;
    logic [9:0]           in_id;
    logic [TIME_BITS-1:0] in_tv;
    logic [EW-1:0]        root;
    logic                 id_ok_in;

    genvar g;
    generate
        for (g = 0; g < NLVL; g++)
        begin : g_lvl
            localparam int LO    = 1 << g;
            localparam int CNT   = (CAPACITY + 1 - LO < LO) ? (CAPACITY + 1 - LO) : LO;
            localparam int PAIRS = (CNT + 1) / 2;
            mhtq_level_cell #(
                .LEVEL (g),
                .EW    (EW),
                .PAIRS (PAIRS)
            ) u_cell (
                .clk     (clk),
                .wr      (cwr),
                .wr_data (cwr_data),
                .rd_pair (rd_pair),
                .rd_word (cell_rd[g])
            );
        end
    endgenerate

    mhtq_ram #(
        .WIDTH (1),
        .DEPTH (NUM_IDS)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < NLVL; i++)
        begin
            if (rd_lvl == LW'(i))
                rd_word = cell_rd[i];
        end
    end

    assign in_id    = s_tdata[9:0];
    assign in_tv    = TIME_BITS'(s_tdata[41:10]);
    assign id_ok_in = 32'(in_id) < NUM_IDS;
    assign root     = cell_rd[0][EW-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !oval_reg || m_tready;

    always_comb
    begin
        logic [NW-1:0]   p, op, on, left, cn, ln, ol;
        logic [LW-1:0]   pl, ll;
        logic [EW-1:0]   par, lc, rc, ch;
        logic            use_r, cond;

        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        lvl_next   = lvl_reg;
        item_next  = item_reg;
        top_next   = top_reg;
        tv_next    = tv_reg;
        dead_next  = dead_reg;
        idok_next  = idok_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        clr_next   = clr_reg;

        oval_next  = oval_reg && !m_tready;
        ost_next   = ost_reg;
        oid_next   = oid_reg;
        otime_next = otime_reg;
        oleft_next = oleft_reg;
        olast_next = olast_reg;

        cwr       = '0;
        cwr_data  = item_reg;
        rd_pair   = '0;
        rd_lvl    = '0;
        ram_we    = 1'b0;
        ram_waddr = IDW'(in_id);
        ram_wdata = 1'b0;
        ram_raddr = '0;

        on    = off_of(n_reg, lvl_reg);
        p     = '0;
        op    = '0;
        pl    = '0;
        par   = '0;
        left  = n_reg << 1;
        lc    = '0;
        rc    = '0;
        ch    = '0;
        cn    = '0;
        use_r = 1'b0;
        ln    = '0;
        ll    = '0;
        ol    = '0;
        cond  = (count_reg != '0) && (root[TIME_BITS-1:0] <= tv_reg);

        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_IDS - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        mhtq_pkg::CMD_ADD:
                        begin
                            if (32'(count_reg) >= CAPACITY)
                            begin
                                res_next   = mhtq_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ram_we     = id_ok_in;
                                ram_wdata  = 1'b0;
                                item_next  = {in_id, in_tv};
                                n_next     = NW'(count_reg) + 1'b1;
                                lvl_next   = lvl_of(NW'(count_reg) + 1'b1);
                                count_next = count_reg + 1'b1;
                                state_next = S_UP;
                            end
                        end
                        mhtq_pkg::CMD_CANCEL:
                        begin
                            ram_we     = id_ok_in;
                            ram_wdata  = 1'b1;
                            res_next   = mhtq_pkg::ST_OK;
                            state_next = S_RESP;
                        end
                        mhtq_pkg::CMD_TICK:
                        begin
                            tv_next    = in_tv;
                            pend_next  = 1'b0;
                            state_next = S_CHK;
                        end
                        default:
                        begin
                            res_next   = mhtq_pkg::ST_NONE;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // one level per cycle: parent from the cell above, write into this one
                cwr.en   = 1'b1;
                cwr.lvl  = lvl_reg;
                cwr.pair = PB'(on >> 1);
                cwr.side = on[0];
                if (n_reg == NW'(1))
                begin
                    res_next   = mhtq_pkg::ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    p       = n_reg >> 1;
                    pl      = lvl_reg - 1'b1;
                    op      = off_of(p, pl);
                    rd_lvl  = pl;
                    rd_pair = PB'(op >> 1);
                    par     = op[0] ? rd_word[2*EW-1:EW] : rd_word[EW-1:0];
                    if (par[TIME_BITS-1:0] <= item_reg[TIME_BITS-1:0])
                    begin
                        res_next   = mhtq_pkg::ST_OK;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cwr_data = par;
                        n_next   = p;
                        lvl_next = pl;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    ost_next   = res_reg;
                    oid_next   = '0;
                    otime_next = '0;
                    oleft_next = 7'(count_reg);
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHK:
            begin
                // a held pop is sent once we know whether another follows
                if (pend_reg)
                begin
                    if (out_free)
                    begin
                        oval_next  = 1'b1;
                        ost_next   = dead_reg ? mhtq_pkg::ST_CANCEL : mhtq_pkg::ST_FIRED;
                        oid_next   = top_reg[EW-1:TIME_BITS];
                        otime_next = 32'(top_reg[TIME_BITS-1:0]);
                        oleft_next = 7'(count_reg);
                        olast_next = !cond;
                        pend_next  = 1'b0;
                        state_next = cond ? S_POPA : S_IDLE;
                    end
                end
                else if (cond)
                begin
                    state_next = S_POPA;
                end
                else if (out_free)
                begin
                    oval_next  = 1'b1;
                    ost_next   = mhtq_pkg::ST_NONE;
                    oid_next   = '0;
                    otime_next = '0;
                    oleft_next = 7'(count_reg);
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POPA:
            begin
                top_next   = root;
                idok_next  = 32'(root[EW-1:TIME_BITS]) < NUM_IDS;
                ram_raddr  = IDW'(root[EW-1:TIME_BITS]);
                count_next = count_reg - 1'b1;
                state_next = S_POPB;
            end
            S_POPB:
            begin
                dead_next = idok_reg && ram_rdata;
                pend_next = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    // last entry moves to the root and sifts down
                    ln         = NW'(count_reg) + 1'b1;
                    ll         = lvl_of(ln);
                    ol         = off_of(ln, ll);
                    rd_lvl     = ll;
                    rd_pair    = PB'(ol >> 1);
                    item_next  = ol[0] ? rd_word[2*EW-1:EW] : rd_word[EW-1:0];
                    n_next     = NW'(1);
                    lvl_next   = '0;
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                cwr.en   = 1'b1;
                cwr.lvl  = lvl_reg;
                cwr.pair = PB'(on >> 1);
                cwr.side = on[0];
                if (left > NW'(count_reg))
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    rd_lvl  = lvl_reg + 1'b1;
                    rd_pair = PB'(on);
                    lc      = rd_word[EW-1:0];
                    rc      = rd_word[2*EW-1:EW];
                    use_r   = ((left + 1'b1) <= NW'(count_reg)) &&
                              (rc[TIME_BITS-1:0] < lc[TIME_BITS-1:0]);
                    ch      = use_r ? rc : lc;
                    cn      = left + NW'(use_r);
                    if (ch[TIME_BITS-1:0] < item_reg[TIME_BITS-1:0])
                    begin
                        cwr_data = ch;
                        n_next   = cn;
                        lvl_next = lvl_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            count_reg <= '0;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        lvl_reg   <= lvl_next;
        item_reg  <= item_next;
        top_reg   <= top_next;
        tv_reg    <= tv_next;
        dead_reg  <= dead_next;
        idok_reg  <= idok_next;
        res_reg   <= res_next;
        ost_reg   <= ost_next;
        oid_reg   <= oid_next;
        otime_reg <= otime_next;
        oleft_reg <= oleft_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = oval_reg;
    assign m_tuser  = ost_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, oleft_reg, otime_reg, oid_reg};

endmodule
`default_nettype wire

[rtl/mhtq_ram.sv]
`default_nettype none
module mhtq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/mhtq_level_cell.sv]
`default_nettype none
// One heap level: entries stored as sibling pairs, {right, left}.
module mhtq_level_cell #(
    parameter int LEVEL = 0,
    parameter int EW    = 42,
    parameter int PAIRS = 1
) (
    input  wire logic                           clk,
    input  wire mhtq_pkg::cell_wr_t             wr,
    input  wire logic [EW-1:0]                  wr_data,
    input  wire logic [mhtq_pkg::PAIR_BITS-1:0] rd_pair,
    output logic      [2*EW-1:0]                rd_word
);

    logic [2*EW-1:0] words [PAIRS];
    logic            hit;

    assign hit = wr.en && (wr.lvl == mhtq_pkg::LVL_BITS'(LEVEL));

    generate
        if (PAIRS == 1)
        begin : g_one
            always_ff @(posedge clk)
            begin
                if (hit)
                begin
                    if (wr.side)
                        words[0][2*EW-1:EW] <= wr_data;
                    else
                        words[0][EW-1:0] <= wr_data;
                end
            end
            assign rd_word = words[0];
        end
        else
        begin : g_many
            localparam int AW = $clog2(PAIRS);
            always_ff @(posedge clk)
            begin
                if (hit)
                begin
                    if (wr.side)
                        words[wr.pair[AW-1:0]][2*EW-1:EW] <= wr_data;
                    else
                        words[wr.pair[AW-1:0]][EW-1:0] <= wr_data;
                end
            end
            assign rd_word = words[rd_pair[AW-1:0]];
        end
    endgenerate

endmodule
`default_nettype wire

[rtl/mhtq_checker.sv]
`default_nettype none
module mhtq_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    logic pop;
    assign pop = (m_tuser == mhtq_pkg::ST_FIRED) || (m_tuser == mhtq_pkg::ST_CANCEL);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // a pop leaves room in the heap
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pop |-> 32'(m_tdata[48:42]) < CAPACITY)
        else $error("pop reports a full heap");

    // only pops carry id and time
    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !pop |-> m_tdata[41:0] == 42'd0)
        else $error("non-pop result carries timer data");

    // non-pop results always end their command
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !pop |-> m_tlast)
        else $error("non-pop result without tlast");

    // no command is taken while a stalled pop is still pending more pops
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pop && !m_tlast |-> !s_tready)
        else $error("command taken mid tick");

endmodule

bind min_heap_timer_queue mhtq_checker #(.CAPACITY(CAPACITY)) u_mhtq_checker (.*);
`default_nettype wire

[bench/min_heap_timer_queue_tb.sv]
`default_nettype none
module min_heap_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mhtq_pkg::*;

    localparam int CAP      = 64;
    localparam int N_IDS    = 1024;
    localparam int MAX_CYC  = 400000;
    localparam int N_RAND   = 30;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  id;
        logic [31:0] tval;
    } command_t;

    // one expected result transfer
    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  id;
        logic [31:0] tval;
        logic [6:0]  left;
        logic        last;
    } outcome_t;

    typedef struct packed {
        logic [9:0]  id;
        logic [31:0] tval;
    } timer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // timer_id[9:0], time_value[41:10], zero pad
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // expired_id[9:0], expired_time[41:10], entries_left[48:42]
    logic [2:0]  m_tuser;   // status
    logic        m_tlast;

    min_heap_timer_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state: its own heap, count and cancel marks
    timer_t   heap_q [CAP];
    int       heap_n;
    bit       marks [N_IDS];
    outcome_t pending_q [$];

    int  errors;
    int  cycle_cnt;
    bit  sending_done;
    bit  hold_off;     // long receiver stall requested by the stimulus

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > MAX_CYC) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("MISMATCH @%0d %s: got %0h want %0h", cycle_cnt, what, got, want);
    endtask

    function automatic outcome_t mk(logic [2:0] st, logic [9:0] id, logic [31:0] tv,
                                    logic last);
        outcome_t o;
        o.status = st; o.id = id; o.tval = tv; o.left = heap_n[6:0]; o.last = last;
        return o;
    endfunction

    // works out the result transfers for one accepted command
    task automatic predict_queue(input command_t c);
        timer_t t, top;
        int pos, up, ch, n;
        n = 0;
        case (c.cmd)
            CMD_ADD: begin
                if (heap_n >= CAP) pending_q.push_back(mk(ST_FULL, '0, '0, 1'b1));
                else begin
                    marks[c.id] = 1'b0;
                    t.id = c.id; t.tval = c.tval;
                    pos = heap_n;
                    heap_n++;
                    // ties stop at the parent
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (heap_q[up].tval <= t.tval) break;
                        heap_q[pos] = heap_q[up];
                        pos = up;
                    end
                    heap_q[pos] = t;
                    pending_q.push_back(mk(ST_OK, '0, '0, 1'b1));
                end
            end
            CMD_CANCEL: begin
                marks[c.id] = 1'b1;
                pending_q.push_back(mk(ST_OK, '0, '0, 1'b1));
            end
            CMD_TICK: begin
                while (heap_n > 0 && heap_q[0].tval <= c.tval) begin
                    top = heap_q[0];
                    heap_n--;
                    if (heap_n > 0) begin
                        t = heap_q[heap_n];
                        pos = 0;
                        while (2 * pos + 1 < heap_n) begin
                            ch = 2 * pos + 1;
                            if (ch + 1 < heap_n && heap_q[ch + 1].tval < heap_q[ch].tval)
                                ch++;
                            if (heap_q[ch].tval < t.tval) begin
                                heap_q[pos] = heap_q[ch];
                                pos = ch;
                            end else break;
                        end
                        heap_q[pos] = t;
                    end
                    pending_q.push_back(mk(marks[top.id] ? ST_CANCEL : ST_FIRED,
                                           top.id, top.tval, 1'b0));
                    n++;
                end
                if (n == 0) pending_q.push_back(mk(ST_NONE, '0, '0, 1'b1));
                else pending_q[$].last = 1'b1;
            end
            default: pending_q.push_back(mk(ST_NONE, '0, '0, 1'b1));
        endcase
    endtask

    // checker: samples at the rising edge
    initial begin
        outcome_t w;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                if (pending_q.size() == 0) report("unexpected transfer", m_tuser, 0);
                else begin
                    w = pending_q.pop_front();
                    if (m_tuser !== w.status) report("status", m_tuser, w.status);
                    if (m_tdata[9:0] !== w.id) report("expired_id", m_tdata[9:0], w.id);
                    if (m_tdata[41:10] !== w.tval)
                        report("expired_time", m_tdata[41:10], w.tval);
                    if (m_tdata[48:42] !== w.left)
                        report("entries_left", m_tdata[48:42], w.left);
                    if (m_tlast !== w.last) report("last", m_tlast, w.last);
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off counted here
    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 3000; hold++) @(negedge clk);
                hold_off = 1'b0;
            end
            if (sending_done || cycle_cnt[9:7] == 3'd0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    command_t stim_q [$];

    function automatic command_t cm(logic [1:0] c, logic [9:0] id, logic [31:0] tv);
        command_t x;
        x.cmd = c; x.id = id; x.tval = tv;
        return x;
    endfunction

    // directed rows; entries_left read off at a glance where the status is fixed
    typedef struct packed {
        command_t cmd;
        bit       fixed;
        outcome_t want;
    } row_t;

    row_t rows [$];

    task automatic add_row(command_t c, bit fx, logic [2:0] st, logic [6:0] left);
        row_t r;
        r.cmd = c; r.fixed = fx;
        r.want = '{status: st, id: '0, tval: '0, left: left, last: 1'b1};
        rows.push_back(r);
    endtask

    // sender: bursts and gaps; one item offered per accepting edge
    task automatic send_one(command_t c);
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {6'd0, c.tval, c.id};
        do @(posedge clk); while (!s_tready);
        predict_queue(c);
        @(negedge clk);
    endtask

    task automatic gap();
        int g;
        s_tvalid <= 1'b0;
        s_tdata  <= 48'({$urandom, $urandom});
        g = $urandom_range(1, 6);
        repeat (g) @(negedge clk);
    endtask

    initial begin
        int burst, k, i, base;
        command_t c;
        errors = 0; heap_n = 0; sending_done = 0; hold_off = 0;
        for (i = 0; i < N_IDS; i++) marks[i] = 1'b0;
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tick, extremes, unknown command, ties, cancel, pops
        add_row(cm(CMD_TICK, 10'd0, 32'hFFFF_FFFF), 1, ST_NONE, 7'd0);
        add_row(cm(CMD_UNKNOWN, 10'h3FF, 32'hFFFF_FFFF), 1, ST_NONE, 7'd0);
        add_row(cm(CMD_ADD, 10'h3FF, 32'hFFFF_FFFF), 1, ST_OK, 7'd1);
        add_row(cm(CMD_ADD, 10'd0, 32'd0), 1, ST_OK, 7'd2);
        add_row(cm(CMD_ADD, 10'd5, 32'd100), 1, ST_OK, 7'd3);
        add_row(cm(CMD_ADD, 10'd6, 32'd100), 1, ST_OK, 7'd4);
        add_row(cm(CMD_ADD, 10'd7, 32'd100), 1, ST_OK, 7'd5);
        add_row(cm(CMD_CANCEL, 10'd6, 32'h5555_5555), 1, ST_OK, 7'd5);
        add_row(cm(CMD_CANCEL, 10'h3FF, 32'hAAAA_AAAA), 1, ST_OK, 7'd5);
        add_row(cm(CMD_TICK, 10'h2AA, 32'd99), 0, ST_NONE, 7'd0);
        add_row(cm(CMD_TICK, 10'h155, 32'd100), 0, ST_NONE, 7'd0);
        add_row(cm(CMD_ADD, 10'd6, 32'd200), 1, ST_OK, 7'd2);   // clears the mark
        add_row(cm(CMD_TICK, 10'd0, 32'hFFFF_FFFF), 0, ST_NONE, 7'd0);
        foreach (rows[i]) begin
            send_one(rows[i].cmd);
            if (rows[i].fixed) begin
                // typed expectation must agree with the predictor's
                if (pending_q[$] !== rows[i].want)
                    report("directed row", pending_q[$], rows[i].want);
            end
        end

        // fill to capacity with the receiver held off, then overflow
        hold_off = 1'b1;
        for (i = 0; i < CAP + 2; i++)
            send_one(cm(CMD_ADD, 10'($urandom_range(0, 15)), $urandom_range(0, 1000)));
        send_one(cm(CMD_TICK, '0, 32'hFFFF_FFFF));

        // random: mostly adds/cancels over a small id set, ticks that advance time
        base = 0;
        k = 0;
        while (k < N_RAND) begin
            burst = $urandom_range(1, 12);
            for (i = 0; i < burst && k < N_RAND; i++, k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: c = cm(CMD_ADD, ($urandom_range(0, 3) == 0) ?
                                          10'($urandom) : 10'($urandom_range(0, 20)),
                                          ($urandom_range(0, 9) == 0) ? $urandom :
                                          base + $urandom_range(0, 300));
                    5, 6: c = cm(CMD_CANCEL, 10'($urandom_range(0, 20)), $urandom);
                    7, 8: begin
                        base += $urandom_range(0, 120);
                        c = cm(CMD_TICK, 10'($urandom), base);
                    end
                    default: c = ($urandom_range(0, 1) == 0) ?
                                 cm(CMD_UNKNOWN, 10'($urandom), $urandom) :
                                 cm(CMD_TICK, 10'($urandom), $urandom);
                endcase
                send_one(c);
            end
            if ($urandom_range(0, 2) != 0) gap();
        end
        send_one(cm(CMD_TICK, 10'd0, 32'hFFFF_FFFF));
        s_tvalid <= 1'b0;
        sending_done = 1'b1;

        while (pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
